### sv/gc3_pkg.sv
// gc3_pkg: shared types, constants and helpers for the 3x3 grey convolution block.
// Used by gc3_cell, grey_convolution_3x3 and the testbench tb; depends on nothing else.
package gc3_pkg;

	// Default frame limits handed to the top level parameters
	localparam int DEFAULT_MAX_WIDTH  = 1024;
	localparam int DEFAULT_MAX_HEIGHT = 1024;

	// Field widths
	localparam int PIX_W     = 8;
	localparam int SIZE_W    = 11;
	localparam int KROW_W    = 24;
	localparam int COORD_W   = 10;
	localparam int PROD_W    = 16;
	localparam int COLSUM_W  = 18;
	localparam int SUM_W     = 20;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	// Rounding: divide by 16 with half away from zero on non-negative sums
	localparam int SCALE_SHIFT = 4;
	localparam int ROUND_BIAS  = 8;
	localparam int PIX_MAX     = 255;

	// Register indexes (byte address / 4)
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_FRAME_WIDTH   = 3'd0;
	localparam reg_idx_t REG_FRAME_HEIGHT  = 3'd1;
	localparam reg_idx_t REG_KERNEL_TOP    = 3'd2;
	localparam reg_idx_t REG_KERNEL_MIDDLE = 3'd3;
	localparam reg_idx_t REG_KERNEL_BOTTOM = 3'd4;

	// Register reset values
	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd480;
	localparam logic [KROW_W-1:0] KERNEL_ROW_RST   = 24'h010101;

	typedef logic [PIX_W-1:0]           pix_t;
	typedef pix_t [2:0]                 col_t;      // [0] top, [1] middle, [2] bottom
	typedef logic signed [PIX_W-1:0]    weight_t;
	typedef weight_t [2:0]              wcol_t;     // [0] top, [1] middle, [2] bottom
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [COLSUM_W-1:0] colsum_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	// Per-cycle control shared by every cell of the window chain
	typedef struct packed {
		logic shift;    // take the neighbor's column
		logic ld_prod;  // register the three products
		logic ld_sum;   // register the column sum
	} cell_ctrl_t;

	// Result tag that travels beside the pixel data
	typedef struct packed {
		logic               emit;
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} meta_t;

	// Divide by 16, round half away from zero, saturate to 0..255
	function automatic pix_t scale_clamp(input sum_t s);
		logic [SUM_W-1:0]             rounded;
		logic [SUM_W-SCALE_SHIFT-1:0] quot;
		rounded = $unsigned(s) + SUM_W'(ROUND_BIAS);
		quot    = rounded[SUM_W-1:SCALE_SHIFT];
		if (s[SUM_W-1]) begin
			return '0;
		end else if (quot > (SUM_W-SCALE_SHIFT)'(PIX_MAX)) begin
			return PIX_W'(PIX_MAX);
		end else begin
			return PIX_W'(quot);
		end
	endfunction

endpackage

### sv/gc3_ram.sv
// gc3_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module gc3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/gc3_cell.sv
// gc3_cell: one column of the 3x3 window with its three multipliers and column adder.
// Depends on gc3_pkg.
module gc3_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  gc3_pkg::cell_ctrl_t ctrl,
	input  gc3_pkg::col_t       col_in,
	input  gc3_pkg::wcol_t      weights,
	output gc3_pkg::col_t       col_out,
	output gc3_pkg::colsum_t    colsum
);
	import gc3_pkg::*;

	col_t    col_q;
	prod_t   prod_s3 [3];
	colsum_t colsum_s4;

	// Window column: advance from the right-hand neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= col_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_prod) begin
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= $signed({1'b0, col_q[i]}) * $signed(weights[i]);
			end
		end
		if (ctrl.ld_sum) begin
			colsum_s4 <= colsum_t'(prod_s3[0]) + colsum_t'(prod_s3[1])
				+ colsum_t'(prod_s3[2]);
		end
	end

	assign col_out = col_q;
	assign colsum  = colsum_s4;

endmodule

### sv/grey_convolution_3x3.sv
// grey_convolution_3x3: 3x3 signed-weight convolution over a raster stream of grey pixels.
// Depends on gc3_pkg, gc3_ram (line stores) and gc3_cell (window columns).
//
// Channel  Dir   Handshake                        Contents
// s_*      in    s_tvalid/s_tready                s_tdata[7:0] pixel
// m_*      out   m_tvalid/m_tready                m_tdata value/out_row/out_col, m_tlast
// apb      in    psel/penable/pwrite, pready = 1  frame size and kernel rows
//
// One pixel per clock sustained unless the output stalls; the single read and single
// write per cycle of the line store RAM set that figure. Each result passes
// stages 1 to 4 and the output register. Reset clears counters, valid bits and
// registers; the line store is not cleared. Back-pressure ripples back stage by
// stage, so empty stages still accept while a result waits at the output register.
module grey_convolution_3x3 #(
	parameter int MAX_WIDTH  = gc3_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = gc3_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB-style configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gc3_pkg::PADDR_W-1:0]    paddr,
	input  logic [gc3_pkg::PDATA_W-1:0]    pwdata,
	output logic [gc3_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// Pixel stream in
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] pixel
	// Result stream out
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [7:0] value, [17:8] out_row,
	                                                  // [27:18] out_col, [31:28] zero
	output logic                           m_tlast    // frame_last
);
	import gc3_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int CWP = CW + 1;
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int RWP = RW + 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0] frame_width_q;
	logic [SIZE_W-1:0] frame_height_q;
	logic [KROW_W-1:0] kernel_q [3];   // [0] top, [1] middle, [2] bottom
	logic              cfg_wr;
	logic              size_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	// A size write restarts the frame at row 0, column 0
	assign size_wr = cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			kernel_q[0]    <= KERNEL_ROW_RST;
			kernel_q[1]    <= KERNEL_ROW_RST;
			kernel_q[2]    <= KERNEL_ROW_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:   frame_width_q  <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q <= pwdata[SIZE_W-1:0];
				REG_KERNEL_TOP:    kernel_q[0]    <= pwdata[KROW_W-1:0];
				REG_KERNEL_MIDDLE: kernel_q[1]    <= pwdata[KROW_W-1:0];
				REG_KERNEL_BOTTOM: kernel_q[2]    <= pwdata[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FRAME_WIDTH:   prdata = PDATA_W'(frame_width_q);
			REG_FRAME_HEIGHT:  prdata = PDATA_W'(frame_height_q);
			REG_KERNEL_TOP:    prdata = PDATA_W'(kernel_q[0]);
			REG_KERNEL_MIDDLE: prdata = PDATA_W'(kernel_q[1]);
			REG_KERNEL_BOTTOM: prdata = PDATA_W'(kernel_q[2]);
			default:           prdata = '0;
		endcase
	end

	// Effective frame size: clamp to 3..MAX
	logic [CWP-1:0] w_eff;
	logic [RWP-1:0] h_eff;

	always_comb begin
		if (frame_width_q < SIZE_W'(3)) begin
			w_eff = CWP'(3);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CWP'(MAX_WIDTH);
		end else begin
			w_eff = CWP'(frame_width_q);
		end
		if (frame_height_q < SIZE_W'(3)) begin
			h_eff = RWP'(3);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = RWP'(MAX_HEIGHT);
		end else begin
			h_eff = RWP'(frame_height_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage handshake: each stage loads when empty or when its successor loads
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_out;
	logic s_accept;

	assign ld_out   = !out_valid_q || m_tready;
	assign ld_s4    = !v_s4 || ld_out;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign s_tready = ld_s1;
	assign s_accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Position counters: column and row of the next pixel
	// ------------------------------------------------------------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_end;
	logic          row_end;
	meta_t         meta_in;

	assign col_end = (CWP'(col_q) + CWP'(1)) >= w_eff;
	assign row_end = (RWP'(row_q) + RWP'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (size_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Tag the pixel: it completes the window of the interior pixel one up, one left
	always_comb begin
		meta_in.emit = (row_q >= RW'(2)) && (col_q >= CW'(2));
		meta_in.last = row_end && col_end;
		meta_in.row  = COORD_W'(row_q - RW'(1));
		meta_in.col  = COORD_W'(col_q - CW'(1));
	end

	// ------------------------------------------------------------------
	// Stage 1: line store read in flight
	// ------------------------------------------------------------------
	meta_t         meta_s1, meta_s2, meta_s3, meta_s4;
	pix_t          pix_s1;
	logic [CW-1:0] addr_s1;
	logic [15:0]   ram_rdata;
	cell_ctrl_t    cell_ctrl;
	col_t          new_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= s_tvalid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (ld_s3) begin
				v_s3 <= v_s2;
			end
			if (ld_s4) begin
				v_s4 <= v_s3;
			end
			// Drop border pixels here: they moved the window but carry no result
			if (ld_out) begin
				out_valid_q <= v_s4 && meta_s4.emit;
			end
		end
	end

	assign cell_ctrl.shift   = ld_s2 && v_s1;
	assign cell_ctrl.ld_prod = ld_s3 && v_s2;
	assign cell_ctrl.ld_sum  = ld_s4 && v_s3;

	always_ff @(posedge clk) begin
		if (s_accept) begin
			meta_s1 <= meta_in;
			pix_s1  <= s_tdata;
			addr_s1 <= col_q;
		end
		if (cell_ctrl.shift) begin
			meta_s2 <= meta_s1;
		end
		if (cell_ctrl.ld_prod) begin
			meta_s3 <= meta_s2;
		end
		if (cell_ctrl.ld_sum) begin
			meta_s4 <= meta_s3;
		end
	end

	// Line store: [7:0] row r-2, [15:8] row r-1. Read on accept, write back as the
	// item leaves stage 1; consecutive items always sit at different columns.
	gc3_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (cell_ctrl.shift),
		.waddr (addr_s1),
		.wdata ({pix_s1, ram_rdata[15:8]}),
		.re    (s_accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign new_col[0] = ram_rdata[7:0];
	assign new_col[1] = ram_rdata[15:8];
	assign new_col[2] = pix_s1;

	// ------------------------------------------------------------------
	// Window chain: cell 2 takes the new column, each cell hands its column left
	// ------------------------------------------------------------------
	col_t    cell_col [3];
	wcol_t   cell_w   [3];
	colsum_t cell_sum [3];

	for (genvar j = 0; j < 3; j++) begin : g_cell
		for (genvar i = 0; i < 3; i++) begin : g_w
			assign cell_w[j][i] = weight_t'(kernel_q[i][8*j +: 8]);
		end

		if (j == 2) begin : g_head
			gc3_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (cell_ctrl),
				.col_in  (new_col),
				.weights (cell_w[j]),
				.col_out (cell_col[j]),
				.colsum  (cell_sum[j])
			);
		end else begin : g_body
			gc3_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (cell_ctrl),
				.col_in  (cell_col[j+1]),
				.weights (cell_w[j]),
				.col_out (cell_col[j]),
				.colsum  (cell_sum[j])
			);
		end
	end

	// ------------------------------------------------------------------
	// Final sum, scale and output register
	// ------------------------------------------------------------------
	sum_t               total;
	pix_t               value_q;
	logic [COORD_W-1:0] out_row_q;
	logic [COORD_W-1:0] out_col_q;
	logic               out_last_q;

	assign total = sum_t'(cell_sum[0]) + sum_t'(cell_sum[1]) + sum_t'(cell_sum[2]);

	always_ff @(posedge clk) begin
		if (ld_out && v_s4 && meta_s4.emit) begin
			value_q    <= scale_clamp(total);
			out_row_q  <= meta_s4.row;
			out_col_q  <= meta_s4.col;
			out_last_q <= meta_s4.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_col_q, out_row_q, value_q};
	assign m_tlast  = out_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		CWP'(col_q) < w_eff)
		else $error("column counter beyond frame width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		RWP'(row_q) < h_eff)
		else $error("row counter beyond frame height");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !cfg_wr && !col_end) |=> (col_q == $past(col_q) + CW'(1)))
		else $error("column counter skipped on accepted pixel");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s4))
		else $error("result raised without an item in the last stage");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for grey_convolution_3x3, with a cycle-free predictor of the filter.
// Depends on gc3_pkg for widths, register indexes and reset values, and on the block itself.
module tb;
	import gc3_pkg::*;

	localparam int MAX_W         = DEFAULT_MAX_WIDTH;
	localparam int MAX_H         = DEFAULT_MAX_HEIGHT;
	localparam int WIDE_W        = 100;   // row width for the single wide frame
	localparam int RANDOM_PIXELS = 950;
	localparam int TAIL_CYCLES   = 20;    // well past the pixel-to-result delay of the pipeline
	localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction before giving up

	typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_BRIGHT} pix_style_t;

	typedef struct packed {
		pix_t               value;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} filtered_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]   pwdata   = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata  = '0;    // [7:0] pixel
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;          // [7:0] value, [17:8] out_row, [27:18] out_col
	logic                 m_tlast;          // frame_last

	grey_convolution_3x3 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Predictor state: configuration copy, line stores, window and frame position.
	logic [SIZE_W-1:0]  cfg_width  = FRAME_WIDTH_RST;
	logic [SIZE_W-1:0]  cfg_height = FRAME_HEIGHT_RST;
	logic [KROW_W-1:0]  kernel_rows [3] = '{KERNEL_ROW_RST, KERNEL_ROW_RST, KERNEL_ROW_RST};
	logic [PDATA_W-1:0] reg_shadow [5] = '{32'(FRAME_WIDTH_RST), 32'(FRAME_HEIGHT_RST),
		32'(KERNEL_ROW_RST), 32'(KERNEL_ROW_RST), 32'(KERNEL_ROW_RST)};
	pix_t               row_above [MAX_W];
	pix_t               row_prev [MAX_W];
	pix_t               win [3][3] = '{default: '0};
	int                 pos_col = 0;
	int                 pos_row = 0;

	filtered_t          expected_filtered [$];
	int                 fail_count  = 0;
	int                 pixels_sent = 0;
	int                 burst_left  = 0;
	int                 idle_cycles = 0;
	int                 rx_span     = 0;
	int                 rx_mode     = 0;

	// Free-running clock, 20 ns period.
	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the predictor by one accepted pixel and queue the result it causes, if any.
	function automatic void convolve_pixel(input pix_t px);
		int        w;
		int        h;
		int        acc;
		int        q;
		weight_t   wt;
		filtered_t res;
		// Out-of-range sizes are used clamped.
		w = (cfg_width < 3) ? 3 : (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
		h = (cfg_height < 3) ? 3 : (cfg_height > MAX_H) ? MAX_H : int'(cfg_height);
		// Shift the window left and bring in the new column from the line stores.
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = row_above[pos_col];
		win[1][2] = row_prev[pos_col];
		win[2][2] = px;
		row_above[pos_col] = row_prev[pos_col];
		row_prev[pos_col]  = px;
		// A full neighbourhood exists once two rows and two columns are behind us.
		if (pos_row >= 2 && pos_col >= 2) begin
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					wt  = kernel_rows[i][8*j +: 8];
					acc += int'(win[i][j]) * int'(wt);
				end
			end
			// Divide by 16 rounding half away from zero; negatives saturate to black.
			if (acc < 0) begin
				q = 0;
			end else begin
				q = (acc + 8) >>> 4;
				if (q > 255) begin
					q = 255;
				end
			end
			res.value = pix_t'(q);
			res.row   = COORD_W'(pos_row - 1);
			res.col   = COORD_W'(pos_col - 1);
			res.last  = (pos_row + 1 >= h) && (pos_col + 1 >= w);
			expected_filtered.push_back(res);
		end
		// Step the raster position; wrap at the end of the row and of the frame.
		pos_col++;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= h) begin
				pos_row = 0;
			end
		end
	endfunction

	// Send one pixel. The sender works in bursts; a burst starts after a random gap.
	task automatic push_pixel(input pix_t px);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// Transaction accepted at this edge.
		burst_left--;
		pixels_sent++;
		convolve_pixel(px);
	endtask

	task automatic stream_pixels(input int count, input pix_style_t style);
		pix_t px;
		for (int n = 0; n < count; n++) begin
			case (style)
				PIX_EXTREME: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				PIX_BRIGHT:  px = 8'hFF;
				default: begin
					// Dim pixels now and then to land on the rounding steps.
					px = ($urandom_range(0, 3) == 0) ? pix_t'($urandom_range(0, 31))
					                                 : pix_t'($urandom());
				end
			endcase
			push_pixel(px);
		end
	endtask

	// Drop valid, wait for every pending result, then let the pipeline empty of
	// pixels that cause no result.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_filtered.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Read a register back and compare it with the shadow copy.
	task automatic reg_check(input reg_idx_t idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== reg_shadow[idx]) begin
			$error("prdata[%0d]: expected %h, actual %h", idx, reg_shadow[idx], prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write a register (block idle), update the predictor, then read back a register that exists.
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx) inside
			REG_FRAME_WIDTH: begin
				// A size write restarts the frame.
				cfg_width = data[SIZE_W-1:0];
				reg_shadow[idx] = 32'(cfg_width);
				pos_col = 0;
				pos_row = 0;
			end
			REG_FRAME_HEIGHT: begin
				cfg_height = data[SIZE_W-1:0];
				reg_shadow[idx] = 32'(cfg_height);
				pos_col = 0;
				pos_row = 0;
			end
			REG_KERNEL_TOP, REG_KERNEL_MIDDLE, REG_KERNEL_BOTTOM: begin
				// Kernel rows change the weights only; the frame position is kept.
				kernel_rows[2'(idx - REG_KERNEL_TOP)] = data[KROW_W-1:0];
				reg_shadow[idx] = 32'(data[KROW_W-1:0]);
			end
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx <= REG_KERNEL_BOTTOM) begin
			reg_check(idx);
		end
	endtask

	task automatic set_frame(input int w, input int h);
		reg_write(REG_FRAME_WIDTH, ($urandom() & ~32'h7FF) | 32'(w));
		reg_write(REG_FRAME_HEIGHT, ($urandom() & ~32'h7FF) | 32'(h));
	endtask

	task automatic set_kernel(input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
	                          input logic [KROW_W-1:0] bot);
		reg_write(REG_KERNEL_TOP, ($urandom() & 32'hFF000000) | 32'(top));
		reg_write(REG_KERNEL_MIDDLE, ($urandom() & 32'hFF000000) | 32'(mid));
		reg_write(REG_KERNEL_BOTTOM, ($urandom() & 32'hFF000000) | 32'(bot));
	endtask

	// Registers must read their reset values before anything is written.
	task automatic test_reset_values();
		for (int k = 0; k <= int'(REG_KERNEL_BOTTOM); k++) begin
			reg_check(reg_idx_t'(k));
		end
	endtask

	// Small frame under the reset kernel (box sum), black and white pixels only.
	task automatic test_default_kernel();
		set_frame(5, 3);
		stream_pixels(15, PIX_EXTREME);
		drain_results();
	endtask

	// Largest positive weights saturate high, most negative weights saturate low.
	task automatic test_kernel_extremes();
		set_frame(3, 3);
		set_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
		stream_pixels(9, PIX_BRIGHT);
		drain_results();
		set_kernel(24'h808080, 24'h808080, 24'h808080);
		stream_pixels(9, PIX_BRIGHT);
		drain_results();
	endtask

	// Size clamping at the low end and one wide frame.
	task automatic test_size_limits();
		set_kernel(24'h01FF02, 24'h03FE01, 24'hFF0201);
		set_frame(0, 1);          // clamps to 3 x 3
		stream_pixels(9, PIX_RANDOM);
		drain_results();
		set_frame(WIDE_W, 3);     // long rows, columns well past the random frames
		stream_pixels(WIDE_W * 3, PIX_RANDOM);
		drain_results();
	endtask

	// Kernel rewrite mid-frame keeps the position; size rewrite mid-frame restarts.
	task automatic test_midframe_writes();
		set_frame(8, 6);
		set_kernel(24'h000100, 24'h01F801, 24'h000100);
		stream_pixels(3 * 8 + 4, PIX_RANDOM);
		drain_results();
		reg_write(REG_KERNEL_MIDDLE, 32'(24'h02F402));
		stream_pixels(6 * 8 - (3 * 8 + 4), PIX_RANDOM);
		drain_results();
		set_frame(6, 5);
		stream_pixels(13, PIX_RANDOM);
		drain_results();
		reg_write(REG_FRAME_WIDTH, 32'd7);
		stream_pixels(7 * 5, PIX_RANDOM);
		drain_results();
	endtask

	// Writes to the unused addresses leave every register and the filter alone.
	task automatic test_unknown_registers();
		for (int k = int'(REG_KERNEL_BOTTOM) + 1; k < 2 ** $bits(reg_idx_t); k++) begin
			reg_write(reg_idx_t'(k), $urandom());
		end
		test_reset_values();
		stream_pixels(2 * 7 * 5, PIX_RANDOM);
		drain_results();
	endtask

	// Random frames: mostly complete frames (sometimes two back to back so the
	// counters wrap), now and then a frame cut short and restarted by a size write.
	task automatic test_random_frames();
		int              stop_at;
		int              w;
		int              h;
		int              wc;
		int              hc;
		int              px_count;
		logic [KROW_W-1:0] krow;
		stop_at = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0:       w = $urandom_range(0, 2);
				1:       w = $urandom_range(13, 48);
				default: w = $urandom_range(3, 12);
			endcase
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			set_frame(w, h);
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 2))
						0: krow = KROW_W'($urandom());
						1: krow = {8'($urandom_range(0, 6) - 3), 8'($urandom_range(0, 6) - 3),
						           8'($urandom_range(0, 6) - 3)};
						default: krow = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
						                 8'($urandom_range(0, 3))};
					endcase
					reg_write(reg_idx_t'(int'(REG_KERNEL_TOP) + k),
					          ($urandom() & 32'hFF000000) | 32'(krow));
				end
			end
			wc = (w < 3) ? 3 : w;
			hc = (h < 3) ? 3 : h;
			if ($urandom_range(0, 7) == 0) begin
				px_count = $urandom_range(1, wc * hc - 1);
			end else begin
				px_count = wc * hc * $urandom_range(1, 2);
			end
			stream_pixels(px_count, PIX_RANDOM);
			drain_results();
		end
	endtask

	// Receiver: switch between stall patterns after a random span.
	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_span = $urandom_range(8, 120);
			rx_mode = $urandom_range(0, 3);
		end
		rx_span--;
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			2:       m_tready <= rx_span[1];              // ready follows bit 1 of the span counter
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Compare each result transaction with the oldest prediction, field by field.
	always @(posedge clk) begin : check_results
		filtered_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_filtered.size() == 0) begin
				$error("unexpected result: tdata %h tlast %b", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = expected_filtered.pop_front();
				if (m_tdata[PIX_W-1:0] !== want.value) begin
					$error("value: expected %0d, actual %0d", want.value, m_tdata[PIX_W-1:0]);
					fail_count++;
				end
				if (m_tdata[PIX_W +: COORD_W] !== want.row) begin
					$error("out_row: expected %0d, actual %0d", want.row,
					       m_tdata[PIX_W +: COORD_W]);
					fail_count++;
				end
				if (m_tdata[PIX_W+COORD_W +: COORD_W] !== want.col) begin
					$error("out_col: expected %0d, actual %0d", want.col,
					       m_tdata[PIX_W+COORD_W +: COORD_W]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("frame_last: expected %0d, actual %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no transaction happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL grey_convolution_3x3");
			$finish;
		end
	end

	initial begin : run_tests
		// Hold reset from the start, release it once, never assert it again.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_default_kernel();
		test_kernel_extremes();
		test_size_limits();
		test_midframe_writes();
		test_unknown_registers();
		test_random_frames();
		drain_results();
		if (expected_filtered.size() != 0) begin
			$error("%0d results never arrived", expected_filtered.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("PASS grey_convolution_3x3");
		end else begin
			$display("FAIL grey_convolution_3x3");
		end
		$finish;
	end

endmodule
